[rtl/core/dqfb_pkg.sv]
package dqfb_pkg;

  // Name handling limits and field widths
  localparam int MAX_NAME = 255;
  localparam int NAME_W   = 10;
  localparam int OFF_W    = 10;

  // ID table is stored as rows of this many slots
  localparam int ROW_BITS = 16;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Result status codes
  localparam logic [1:0] ST_WRITE    = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_NO_ID    = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // Input function codes
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Characters of interest in the host name
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Index of the done result in the end-of-name burst
  localparam logic [4:0] BURST_LAST = 5'd18;

  // One queued command: an optional byte write, an optional end of name,
  // or an ID release
  typedef struct packed {
    logic              wr_en;
    logic [OFF_W-1:0]  wr_offset;
    logic [7:0]        wr_byte;
    logic              fin_en;
    logic              fin_long;
    logic [NAME_W-1:0] fin_len;
    logic [7:0]        fin_label;
    logic              rel_en;
    logic [9:0]        rel_id;
  } cmd_t;

endpackage

[rtl/core/dns_query_frame_builder.sv]
// Channel  Handshake          Payload
// in       in_valid/in_stall   func, name_byte, last, release_id
// out      out_valid/out_stall status, write_offset, write_byte, message_length,
//                              query_id, end_of_run
//
// A name byte is pushed by the front when accepted; the back pops it, then writes the byte.
// End of name: S_FIN starts it; each ID-table row of 16 slots is read (S_SCAN_RD)
// and checked (S_SCAN_CHK); the result burst (S_BURST) then ends with the done result.
// A release reads one ID-table row, then clears the slot bit and writes the row back.
// After reset the ID table is cleared one row a cycle, all ceil(ID_SLOTS/16) rows,
// with in_stall high; in_stall is also high while the 4-entry command queue is full.
// out_stall holds the output register and pauses the back part only.
module dns_query_frame_builder #(
  parameter int ID_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  name_byte,
  input  logic        last,
  input  logic [9:0]  release_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [9:0]  write_offset,
  output logic [7:0]  write_byte,
  output logic [9:0]  message_length,
  output logic [9:0]  query_id,
  output logic        end_of_run
);

  dqfb_pkg::cmd_t push_cmd;
  dqfb_pkg::cmd_t q_dout;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  logic           clearing;

  dqfb_front #(
    .ID_SLOTS (ID_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .name_byte  (name_byte),
    .last       (last),
    .release_id (release_id),
    .q_full     (q_full),
    .clearing   (clearing),
    .push       (push),
    .cmd        (push_cmd)
  );

  dqfb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_cmd),
    .pop   (pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  dqfb_back #(
    .ID_SLOTS (ID_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_dout         (q_dout),
    .pop            (pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .write_offset   (write_offset),
    .write_byte     (write_byte),
    .message_length (message_length),
    .query_id       (query_id),
    .end_of_run     (end_of_run)
  );

endmodule

[rtl/core/dqfb_ram.sv]
module dqfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/dqfb_front.sv]
module dqfb_front #(
  parameter int ID_SLOTS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            func,
  input  logic [7:0]      name_byte,
  input  logic            last,
  input  logic [9:0]      release_id,
  input  logic            q_full,
  input  logic            clearing,
  output logic            push,
  output dqfb_pkg::cmd_t  cmd
);

  logic [dqfb_pkg::NAME_W-1:0] name_length;
  logic [dqfb_pkg::NAME_W-1:0] name_length_next;
  logic [7:0]                  label_length;
  logic [7:0]                  label_length_next;
  logic                        name_ended;
  logic                        name_ended_next;
  logic                        too_long;
  logic                        too_long_next;
  logic                        accept;
  logic                        rel_in_range;

  assign in_stall     = q_full | clearing;
  assign accept       = in_valid & ~in_stall;
  assign rel_in_range = {7'd0, release_id} < 17'(ID_SLOTS);

  // Classify the transaction and build the command for the back part
  always_comb begin
    name_length_next  = name_length;
    label_length_next = label_length;
    name_ended_next   = name_ended;
    too_long_next     = too_long;
    cmd               = '0;
    if (func == dqfb_pkg::FUNC_RELEASE) begin
      cmd.rel_en = rel_in_range;
      cmd.rel_id = release_id;
    end else begin
      if (!name_ended) begin
        priority if (name_byte == dqfb_pkg::CH_NL || name_byte == dqfb_pkg::CH_NUL) begin
          name_ended_next = 1'b1;
        end else if (name_length >= dqfb_pkg::NAME_W'(dqfb_pkg::MAX_NAME)) begin
          too_long_next = 1'b1;
        end else if (name_byte == dqfb_pkg::CH_DOT) begin
          cmd.wr_en         = 1'b1;
          cmd.wr_offset     = dqfb_pkg::OFF_W'(12) + name_length - {2'd0, label_length};
          cmd.wr_byte       = label_length;
          label_length_next = 8'd0;
          name_length_next  = name_length + 1'b1;
        end else begin
          cmd.wr_en         = 1'b1;
          cmd.wr_offset     = dqfb_pkg::OFF_W'(13) + name_length;
          cmd.wr_byte       = name_byte;
          label_length_next = label_length + 1'b1;
          name_length_next  = name_length + 1'b1;
        end
      end
      if (last) begin
        cmd.fin_en        = 1'b1;
        cmd.fin_long      = too_long_next;
        cmd.fin_len       = name_length_next;
        cmd.fin_label     = label_length_next;
        name_length_next  = '0;
        label_length_next = 8'd0;
        name_ended_next   = 1'b0;
        too_long_next     = 1'b0;
      end
    end
  end

  assign push = accept & (cmd.wr_en | cmd.fin_en | cmd.rel_en);

  // Advance name state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      name_length  <= '0;
      label_length <= 8'd0;
      name_ended   <= 1'b0;
      too_long     <= 1'b0;
    end else if (accept) begin
      name_length  <= name_length_next;
      label_length <= label_length_next;
      name_ended   <= name_ended_next;
      too_long     <= too_long_next;
    end
  end

endmodule

[rtl/core/dqfb_queue.sv]
module dqfb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dqfb_pkg::cmd_t din,
  input  logic           pop,
  output dqfb_pkg::cmd_t dout,
  output logic           full,
  output logic           empty
);

  dqfb_pkg::cmd_t                mem [dqfb_pkg::QUEUE_DEPTH];
  logic [dqfb_pkg::QPTR_W-1:0]   wr_ptr;
  logic [dqfb_pkg::QPTR_W-1:0]   rd_ptr;
  logic [dqfb_pkg::QCNT_W-1:0]   count;

  assign full  = count == dqfb_pkg::QCNT_W'(dqfb_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/dqfb_back.sv]
module dqfb_back #(
  parameter int ID_SLOTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  dqfb_pkg::cmd_t               q_dout,
  output logic                         pop,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [dqfb_pkg::OFF_W-1:0]   write_offset,
  output logic [7:0]                   write_byte,
  output logic [9:0]                   message_length,
  output logic [9:0]                   query_id,
  output logic                         end_of_run
);

  localparam int ROWS     = (ID_SLOTS + dqfb_pkg::ROW_BITS - 1) / dqfb_pkg::ROW_BITS;
  localparam int ROW_W    = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int LAST_BITS = ID_SLOTS - (ROWS - 1) * dqfb_pkg::ROW_BITS;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [16:0] LAST_ONES = (17'd1 << LAST_BITS) - 17'd1;
  localparam logic [dqfb_pkg::ROW_BITS-1:0] PAD_MASK = ~LAST_ONES[dqfb_pkg::ROW_BITS-1:0];

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_WRITE    = 4'd2;
  localparam logic [3:0] S_FIN      = 4'd3;
  localparam logic [3:0] S_REL_RD   = 4'd4;
  localparam logic [3:0] S_REL_WR   = 4'd5;
  localparam logic [3:0] S_SCAN_RD  = 4'd6;
  localparam logic [3:0] S_SCAN_CHK = 4'd7;
  localparam logic [3:0] S_BURST    = 4'd8;

  logic [3:0]                   state;
  logic [ROW_W-1:0]             row;
  logic [3:0]                   bit_sel;
  logic [4:0]                   step;
  logic [15:0]                  id;
  dqfb_pkg::cmd_t               cur;

  logic                         ram_we;
  logic [ROW_W-1:0]             ram_waddr;
  logic [dqfb_pkg::ROW_BITS-1:0] ram_wdata;
  logic [dqfb_pkg::ROW_BITS-1:0] ram_rdata;
  logic [dqfb_pkg::ROW_BITS-1:0] row_busy;
  logic [dqfb_pkg::ROW_BITS-1:0] bit_onehot;
  logic [dqfb_pkg::ROW_BITS-1:0] free_onehot;
  logic [3:0]                   free_bit;
  logic                         row_has_free;
  logic [16:0]                  rel_ext;
  logic                         out_free;

  logic                         load;
  logic [1:0]                   load_status;
  logic [dqfb_pkg::OFF_W-1:0]   load_offset;
  logic [7:0]                   load_byte;
  logic [9:0]                   load_length;
  logic [9:0]                   load_qid;
  logic                         load_eor;
  logic [3:0]                   hdr_k;

  dqfb_ram #(
    .WIDTH (dqfb_pkg::ROW_BITS),
    .DEPTH (ROWS)
  ) u_id_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (row),
    .rdata (ram_rdata)
  );

  assign clearing = state == S_CLEAR;
  assign out_free = ~out_valid | ~out_stall;
  assign rel_ext  = {7'd0, q_dout.rel_id};

  // Treat slots beyond the table as busy
  assign row_busy     = ram_rdata | ((row == LAST_ROW) ? PAD_MASK : '0);
  assign row_has_free = ~&row_busy;
  assign bit_onehot   = dqfb_pkg::ROW_BITS'(1) << bit_sel;
  assign free_onehot  = dqfb_pkg::ROW_BITS'(1) << free_bit;

  // Find the lowest free slot in the current row
  always_comb begin
    free_bit = 4'd0;
    for (int i = dqfb_pkg::ROW_BITS - 1; i >= 0; i--) begin
      if (!row_busy[i]) begin
        free_bit = 4'(i);
      end
    end
  end

  // ID table writes: clearing pass, allocation, release
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = row;
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_SCAN_CHK: begin
        ram_we    = row_has_free;
        ram_wdata = ram_rdata | free_onehot;
      end
      S_REL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~bit_onehot;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Result content for each state and burst step
  assign hdr_k = 4'(step - 5'd6);

  always_comb begin
    load        = 1'b0;
    load_status = dqfb_pkg::ST_WRITE;
    load_offset = '0;
    load_byte   = 8'd0;
    load_length = 10'd0;
    load_qid    = 10'd0;
    load_eor    = 1'b0;
    pop         = 1'b0;
    unique case (state)
      S_IDLE: begin
        pop = ~q_empty;
      end
      S_WRITE: begin
        load        = out_free;
        load_offset = cur.wr_offset;
        load_byte   = cur.wr_byte;
        load_eor    = ~cur.fin_en;
      end
      S_FIN: begin
        load        = out_free & cur.fin_long;
        load_status = dqfb_pkg::ST_TOO_LONG;
        load_eor    = 1'b1;
      end
      S_SCAN_CHK: begin
        load        = out_free & ~row_has_free & (row == LAST_ROW);
        load_status = dqfb_pkg::ST_NO_ID;
        load_eor    = 1'b1;
      end
      S_BURST: begin
        load = out_free;
        priority if (step == 5'd0) begin
          load_offset = dqfb_pkg::OFF_W'(12) + cur.fin_len - {2'd0, cur.fin_label};
          load_byte   = cur.fin_label;
        end else if (step <= 5'd5) begin
          load_offset = cur.fin_len + dqfb_pkg::OFF_W'(5'd12 + step);
          load_byte   = (step == 5'd3 || step == 5'd5) ? 8'd1 : 8'd0;
        end else if (step < dqfb_pkg::BURST_LAST) begin
          load_offset = dqfb_pkg::OFF_W'(hdr_k);
          unique case (hdr_k)
            4'd0:    load_byte = id[15:8];
            4'd1:    load_byte = id[7:0];
            4'd2:    load_byte = 8'd1;
            4'd5:    load_byte = 8'd1;
            default: load_byte = 8'd0;
          endcase
        end else begin
          load_status = dqfb_pkg::ST_DONE;
          load_length = dqfb_pkg::OFF_W'(18) + cur.fin_len;
          load_qid    = id[9:0];
          load_eor    = 1'b1;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // Sequence commands from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      row   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (row == LAST_ROW) begin
            row   <= '0;
            state <= S_IDLE;
          end else begin
            row <= row + 1'b1;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            priority if (q_dout.rel_en) begin
              row   <= rel_ext[4 +: ROW_W];
              state <= S_REL_RD;
            end else if (q_dout.wr_en) begin
              state <= S_WRITE;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_WRITE: begin
          if (out_free) begin
            state <= cur.fin_en ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (cur.fin_long) begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end else begin
            row   <= '0;
            state <= S_SCAN_RD;
          end
        end
        S_REL_RD: begin
          state <= S_REL_WR;
        end
        S_REL_WR: begin
          state <= S_IDLE;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          priority if (row_has_free) begin
            state <= S_BURST;
          end else if (row != LAST_ROW) begin
            row   <= row + 1'b1;
            state <= S_SCAN_RD;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_BURST: begin
          if (out_free && step == dqfb_pkg::BURST_LAST) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the current command, slot and burst position
  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= q_dout;
      bit_sel <= q_dout.rel_id[3:0];
    end
    if (state == S_SCAN_CHK && row_has_free) begin
      id   <= 16'({row, free_bit});
      step <= 5'd0;
    end else if (state == S_BURST && out_free) begin
      step <= step + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status         <= load_status;
      write_offset   <= load_offset;
      write_byte     <= load_byte;
      message_length <= load_length;
      query_id       <= load_qid;
      end_of_run     <= load_eor;
    end
  end

endmodule
